FILE: design/fpba_pkg.sv
package fpba_pkg;

  // fixed field widths of the words on the ports
  localparam int unsigned PartW   = 4;
  localparam int unsigned AmountW = 16;
  localparam int unsigned ModeW   = 2;

  // placement policy codes
  typedef enum logic [ModeW-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  // item operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_e;

  // input word
  typedef struct packed {
    op_e                op;
    logic [PartW-1:0]   partition;
    logic [AmountW-1:0] amount;
  } alloc_in_t;

  // result word
  typedef struct packed {
    logic               granted;
    logic [PartW-1:0]   chosen_partition;
    logic [AmountW-1:0] remaining;
  } alloc_out_t;

endpackage

FILE: design/fpba_cell.sv
module fpba_cell #(
  parameter int unsigned SizeBits = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CellIdx  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpba_pkg::fit_mode_e mode_i,
  input  logic [SizeBits-1:0] req_i,
  input  logic                wr_en_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  logic [SizeBits-1:0] wr_data_i,
  input  logic                found_i,
  input  logic [IdxW-1:0]     idx_i,
  input  logic [SizeBits-1:0] val_i,
  output logic                found_o,
  output logic [IdxW-1:0]     idx_o,
  output logic [SizeBits-1:0] val_o
);
  import fpba_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [SizeBits-1:0] free_q;
  logic                found_q;
  logic [IdxW-1:0]     idx_q;
  logic [SizeBits-1:0] val_q;
  logic                fits;
  logic                take;

  // does this partition beat the candidate handed in from the left
  assign fits = (free_q >= req_i);

  always_comb begin
    case (mode_i)
      FIT_FIRST: take = fits && (free_q != '0) && !found_i;
      FIT_BEST:  take = fits && (!found_i || (free_q < val_i));
      FIT_WORST: take = fits && (!found_i || (free_q > val_i));
      default:   take = 1'b0;
    endcase
  end

  // free size of this partition
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
    end else if (wr_en_i && (wr_idx_i == MyIdx)) begin
      free_q <= wr_data_i;
    end
  end

  // candidate handed on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= take || found_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= take ? MyIdx : idx_i;
    val_q <= take ? free_q : val_i;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign val_o   = val_q;

endmodule

FILE: design/fit_policy_block_allocator_core.sv
// Partition allocator with first, best and worst fit placement. Each partition's
// free size lives in one cell of a chain; an allocate word sends a candidate down
// the chain one cell per cycle, then a commit state writes the result, and
// allocates are handled one at a time. A load word for a partition in range is
// written straight into its cell and answered from the result register. The
// input is taken whenever the block is idle and the result register is free or
// being drained. fit_mode is written over the cfg channel, which is always ready.
module fit_policy_block_allocator_core #(
  parameter int unsigned NumPartitions = 16,
  parameter int unsigned SizeBits      = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fpba_pkg::ModeW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fpba_pkg::alloc_in_t          in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fpba_pkg::alloc_out_t         out_word_o
);
  import fpba_pkg::*;

  localparam int unsigned IdxW = $clog2(NumPartitions);
  localparam logic [IdxW-1:0] LastCnt = IdxW'(NumPartitions - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     cnt_q;
  logic [SizeBits-1:0] req_q;
  fit_mode_e           fit_mode_q;
  logic                out_vld_q;
  alloc_out_t          out_word_q;

  logic [SizeBits-1:0] amt_s;
  logic                in_range;
  logic                out_free;
  logic                in_fire;
  logic                commit_fire;
  logic                grant;
  logic [SizeBits-1:0] rem_s;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [SizeBits-1:0] wr_data;

  logic [NumPartitions:0] chain_found;
  logic [IdxW-1:0]        chain_idx [NumPartitions+1];
  logic [SizeBits-1:0]    chain_val [NumPartitions+1];

  // handshake and item decode
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign commit_fire = (state_q == ST_COMMIT) && out_free;
  assign amt_s       = SizeBits'(in_word_i.amount);
  assign in_range    = (32'(in_word_i.partition) < 32'(NumPartitions));

  // result of the scan at the end of the chain
  assign grant = chain_found[NumPartitions] && (chain_val[NumPartitions] != '0);
  assign rem_s = chain_val[NumPartitions] - req_q;

  // write port broadcast to the cells
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = IdxW'(in_word_i.partition);
    wr_data = amt_s;
    if (in_fire && (in_word_i.op == OP_LOAD) && in_range) begin
      wr_en = 1'b1;
    end else if (commit_fire && grant) begin
      wr_en   = 1'b1;
      wr_idx  = chain_idx[NumPartitions];
      wr_data = rem_s;
    end
  end

  // empty candidate enters the first cell
  assign chain_found[0] = 1'b0;
  assign chain_idx[0]   = '0;
  assign chain_val[0]   = '0;

  // chain of partition cells
  for (genvar k = 0; k < NumPartitions; k++) begin : g_cell
    fpba_cell #(
      .SizeBits (SizeBits),
      .IdxW     (IdxW),
      .CellIdx  (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .mode_i    (fit_mode_q),
      .req_i     (req_q),
      .wr_en_i   (wr_en),
      .wr_idx_i  (wr_idx),
      .wr_data_i (wr_data),
      .found_i   (chain_found[k]),
      .idx_i     (chain_idx[k]),
      .val_i     (chain_val[k]),
      .found_o   (chain_found[k+1]),
      .idx_o     (chain_idx[k+1]),
      .val_o     (chain_val[k+1])
    );
  end

  // sequencer, policy register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      req_q      <= '0;
      fit_mode_q <= FIT_BEST;
      out_vld_q  <= 1'b0;
      out_word_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        fit_mode_q <= fit_mode_e'(cfg_data_i);
      end
      if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_word_i.op == OP_LOAD) begin
              out_vld_q                   <= 1'b1;
              out_word_q.granted          <= 1'b0;
              out_word_q.chosen_partition <= in_word_i.partition;
              out_word_q.remaining        <= in_range ? AmountW'(amt_s) : '0;
            end else begin
              req_q   <= amt_s;
              cnt_q   <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            if (grant) begin
              out_word_q.granted          <= 1'b1;
              out_word_q.chosen_partition <= PartW'(chain_idx[NumPartitions]);
              out_word_q.remaining        <= AmountW'(rem_s);
            end else begin
              out_word_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: design/fpba_checker.sv
module fpba_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input fpba_pkg::alloc_in_t  in_word_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input fpba_pkg::alloc_out_t out_word_o
);
  import fpba_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // a load word is answered in the next cycle
  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.op == OP_LOAD) |=> out_valid_o)
    else $error("load word not answered in the next cycle");

  // a load never reports a grant
  a_load_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.op == OP_LOAD) |=> !out_word_o.granted)
    else $error("load word reported as granted");

  // an allocate word blocks the input while the chain is searched
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_word_i.op == OP_ALLOC) |=> !in_ready_o)
    else $error("input taken during a search");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
